@@ hw/rtl/bmst_pkg.sv @@
package bmst_pkg;

  localparam int MaxNodes = 64;
  localparam int MaxEdges = 1024;
  localparam int NodeW    = $clog2(MaxNodes);
  localparam int EdgeAW   = $clog2(MaxEdges);
  localparam int CntW     = EdgeAW + 1;
  localparam int NcW      = 7;
  localparam int WeightW  = 32;
  localparam int TotalW   = 40;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_ROUND,
    OP_E_RD,
    OP_R_RD,
    OP_RETIRE,
    OP_CA_RD,
    OP_CA_UPD,
    OP_CB_UPD,
    OP_AP_INIT,
    OP_P_RD,
    OP_PR_RD,
    OP_JOIN,
    OP_SWEEP,
    OP_FINISH
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic scan_end;
    logic edge_ok;
    logic same_root;
    logic any_cross;
    logic r_end;
    logic pick_valid;
    logic sweep_done;
    logic forest_done;
  } status_t;

  typedef struct packed {
    logic               live;
    logic [NodeW-1:0]   a;
    logic [NodeW-1:0]   b;
    logic [WeightW-1:0] w;
  } edge_t;

  typedef struct packed {
    logic [NodeW-1:0]   a;
    logic [NodeW-1:0]   b;
    logic [WeightW-1:0] w;
  } pick_t;

endpackage

@@ hw/rtl/boruvka_mst_engine_top.sv @@
// Minimum spanning forest engine. Edges load one per cycle: pulse start_i with the
// edge on end_a_i/end_b_i/edge_weight_i while busy_o is low; an edge with an end at or
// above node_count, or one past the 1024-entry store, is dropped and flagged. The edge
// with last_edge_i set starts the run and busy_o stays high until it ends. Each round
// scans every stored edge (skipping one already retired, retiring one with both ends in
// one component, and offering one that crosses two components to the cheapest table),
// then walks the 64 roots and relabels the forest for every merge; there are at most
// about log2(node_count)+1 rounds. Results arrive one per result_strobe_o cycle and
// cannot be stalled: the receiver must take every beat. The last beat of a run has
// final_item_o set; a run with no tree edge gives a single beat with edge_valid_o
// clear.
module boruvka_mst_engine_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [bmst_pkg::NodeW-1:0]          end_a_i,
  input  logic [bmst_pkg::NodeW-1:0]          end_b_i,
  input  logic signed [bmst_pkg::WeightW-1:0] edge_weight_i,
  input  logic                                last_edge_i,
  input  logic                                cfg_we_i,
  input  logic [bmst_pkg::NcW-1:0]            cfg_data_i,
  output logic                                result_strobe_o,
  output logic [bmst_pkg::NodeW-1:0]          tree_a_o,
  output logic [bmst_pkg::NodeW-1:0]          tree_b_o,
  output logic signed [bmst_pkg::WeightW-1:0] tree_weight_o,
  output logic signed [bmst_pkg::TotalW-1:0]  running_total_o,
  output logic                                edge_valid_o,
  output logic                                dropped_o,
  output logic                                final_item_o
);
  import bmst_pkg::*;

  cmd_t    cmd;
  status_t status;

  bmst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .last_edge_i (last_edge_i),
    .status_i    (status),
    .cmd_o       (cmd),
    .busy_o      (busy_o)
  );

  bmst_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_we_i        (cfg_we_i),
    .cfg_data_i      (cfg_data_i),
    .end_a_i         (end_a_i),
    .end_b_i         (end_b_i),
    .edge_weight_i   (edge_weight_i),
    .result_strobe_o (result_strobe_o),
    .tree_a_o        (tree_a_o),
    .tree_b_o        (tree_b_o),
    .tree_weight_o   (tree_weight_o),
    .running_total_o (running_total_o),
    .edge_valid_o    (edge_valid_o),
    .dropped_o       (dropped_o),
    .final_item_o    (final_item_o)
  );

endmodule

@@ hw/rtl/bmst_ctrl.sv @@
module bmst_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             last_edge_i,
  input  bmst_pkg::status_t status_i,
  output bmst_pkg::cmd_t   cmd_o,
  output logic             busy_o
);
  import bmst_pkg::*;

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_ROUND    = 4'd1;
  localparam logic [3:0] ST_E_RD     = 4'd2;
  localparam logic [3:0] ST_E_CHK    = 4'd3;
  localparam logic [3:0] ST_R_CHK    = 4'd4;
  localparam logic [3:0] ST_CA_UPD   = 4'd5;
  localparam logic [3:0] ST_CB_UPD   = 4'd6;
  localparam logic [3:0] ST_AP_INIT  = 4'd7;
  localparam logic [3:0] ST_P_RD     = 4'd8;
  localparam logic [3:0] ST_P_CHK    = 4'd9;
  localparam logic [3:0] ST_P_JCHK   = 4'd10;
  localparam logic [3:0] ST_SWEEP    = 4'd11;
  localparam logic [3:0] ST_FINISH   = 4'd12;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = OP_NONE;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.op = OP_LOAD;
          if (last_edge_i) state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd_o.op = OP_ROUND;
        state_d  = ST_E_RD;
      end
      ST_E_RD: begin
        if (status_i.scan_end) begin
          state_d = status_i.any_cross ? ST_AP_INIT : ST_FINISH;
        end else begin
          cmd_o.op = OP_E_RD;
          state_d  = ST_E_CHK;
        end
      end
      ST_E_CHK: begin
        if (status_i.edge_ok) begin
          cmd_o.op = OP_R_RD;
          state_d  = ST_R_CHK;
        end else begin
          state_d = ST_E_RD;
        end
      end
      ST_R_CHK: begin
        // both ends in one component: retire the edge
        if (status_i.same_root) begin
          cmd_o.op = OP_RETIRE;
          state_d  = ST_E_RD;
        end else begin
          cmd_o.op = OP_CA_RD;
          state_d  = ST_CA_UPD;
        end
      end
      ST_CA_UPD: begin
        cmd_o.op = OP_CA_UPD;
        state_d  = ST_CB_UPD;
      end
      ST_CB_UPD: begin
        cmd_o.op = OP_CB_UPD;
        state_d  = ST_E_RD;
      end
      ST_AP_INIT: begin
        cmd_o.op = OP_AP_INIT;
        state_d  = ST_P_RD;
      end
      ST_P_RD: begin
        if (status_i.r_end) begin
          state_d = status_i.forest_done ? ST_FINISH : ST_ROUND;
        end else begin
          cmd_o.op = OP_P_RD;
          state_d  = ST_P_CHK;
        end
      end
      ST_P_CHK: begin
        if (status_i.pick_valid) begin
          cmd_o.op = OP_PR_RD;
          state_d  = ST_P_JCHK;
        end else begin
          state_d = ST_P_RD;
        end
      end
      ST_P_JCHK: begin
        if (status_i.same_root) begin
          state_d = ST_P_RD;
        end else begin
          cmd_o.op = OP_JOIN;
          state_d  = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        cmd_o.op = OP_SWEEP;
        if (status_i.sweep_done) state_d = ST_P_RD;
      end
      ST_FINISH: begin
        cmd_o.op = OP_FINISH;
        state_d  = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

@@ hw/rtl/bmst_dp.sv @@
module bmst_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  bmst_pkg::cmd_t                      cmd_i,
  output bmst_pkg::status_t                   status_o,
  input  logic                                cfg_we_i,
  input  logic [bmst_pkg::NcW-1:0]            cfg_data_i,
  input  logic [bmst_pkg::NodeW-1:0]          end_a_i,
  input  logic [bmst_pkg::NodeW-1:0]          end_b_i,
  input  logic signed [bmst_pkg::WeightW-1:0] edge_weight_i,
  output logic                                result_strobe_o,
  output logic [bmst_pkg::NodeW-1:0]          tree_a_o,
  output logic [bmst_pkg::NodeW-1:0]          tree_b_o,
  output logic signed [bmst_pkg::WeightW-1:0] tree_weight_o,
  output logic signed [bmst_pkg::TotalW-1:0]  running_total_o,
  output logic                                edge_valid_o,
  output logic                                dropped_o,
  output logic                                final_item_o
);
  import bmst_pkg::*;

  // configuration and graph bookkeeping
  logic [NcW-1:0]    node_count_q;
  logic [NcW-1:0]    n_eff;
  logic [CntW-1:0]   cnt_q;
  logic [CntW-1:0]   e_q;
  logic [NcW-1:0]    r_q;
  logic [NodeW:0]    j_q;
  logic [NcW-1:0]    joins_q;
  logic              drop_q;
  logic              any_cross_q;
  logic [TotalW-1:0] total_q;
  logic [TotalW-1:0] total_sum;
  logic              load_fits;

  // edge store
  edge_t             edge_mem [MaxEdges];
  edge_t             ed_q;
  logic [EdgeAW-1:0] ed_addr_q;
  logic              edge_we;
  logic [EdgeAW-1:0] edge_wa;
  edge_t             edge_wd;

  // flattened forest: node -> root, unwritten entries read as the node itself
  logic [NodeW-1:0]    comp_mem [MaxNodes];
  logic [MaxNodes-1:0] comp_v_q;
  logic [NodeW-1:0]    c0_q, c1_q, c0_addr_q, c1_addr_q;
  logic                c0_vq, c1_vq;
  logic                c0_re, c1_re;
  logic [NodeW-1:0]    c0_ra, c1_ra;
  logic [NodeW-1:0]    root0, root1;
  logic [NodeW-1:0]    hi_q, lo_q;
  logic                comp_we;

  // cheapest edge per component root
  pick_t               ch_mem [MaxNodes];
  logic [MaxNodes-1:0] ch_v_q;
  pick_t               ch_q;
  logic                chv_q;
  logic                ch_re, ch_we;
  logic [NodeW-1:0]    ch_ra, ch_wa;
  logic                better;

  // held result until we know whether it is the last one
  pick_t             pend_q;
  logic [TotalW-1:0] pend_tot_q;
  logic              pend_v_q;

  assign n_eff = (node_count_q > NcW'(MaxNodes)) ? NcW'(MaxNodes) : node_count_q;
  assign load_fits = ({1'b0, end_a_i} < n_eff) && ({1'b0, end_b_i} < n_eff) &&
                     (cnt_q < CntW'(MaxEdges));

  assign root0 = c0_vq ? c0_q : c0_addr_q;
  assign root1 = c1_vq ? c1_q : c1_addr_q;

  assign better = !chv_q || ($signed(ed_q.w) < $signed(ch_q.w));
  assign total_sum = total_q + {{(TotalW-WeightW){ch_q.w[WeightW-1]}}, ch_q.w};

  // ---------------- edge store ----------------
  always_comb begin
    edge_we = 1'b0;
    edge_wa = cnt_q[EdgeAW-1:0];
    edge_wd = '{live: 1'b1, a: end_a_i, b: end_b_i, w: edge_weight_i};
    if (cmd_i.op == OP_LOAD) begin
      edge_we = load_fits;
    end else if (cmd_i.op == OP_RETIRE) begin
      edge_we      = 1'b1;
      edge_wa      = ed_addr_q;
      edge_wd      = ed_q;
      edge_wd.live = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (edge_we) edge_mem[edge_wa] <= edge_wd;
    if (cmd_i.op == OP_E_RD) begin
      ed_q      <= edge_mem[e_q[EdgeAW-1:0]];
      ed_addr_q <= e_q[EdgeAW-1:0];
    end
  end

  // ---------------- forest ----------------
  always_comb begin
    c0_re = 1'b0;
    c1_re = 1'b0;
    c0_ra = ed_q.a;
    c1_ra = ed_q.b;
    priority case (cmd_i.op)
      OP_R_RD: begin
        c0_re = 1'b1;
        c1_re = 1'b1;
      end
      OP_PR_RD: begin
        c0_re = 1'b1;
        c1_re = 1'b1;
        c0_ra = ch_q.a;
        c1_ra = ch_q.b;
      end
      OP_SWEEP: begin
        c0_re = !j_q[NodeW];
        c0_ra = j_q[NodeW-1:0];
      end
      default: ;
    endcase
  end

  // sweep writes the node that it read in the previous cycle
  assign comp_we = (cmd_i.op == OP_SWEEP) && (j_q != '0) && (root0 == hi_q);

  always_ff @(posedge clk_i) begin
    if (comp_we) comp_mem[c0_addr_q] <= lo_q;
    if (c0_re) begin
      c0_q      <= comp_mem[c0_ra];
      c0_vq     <= comp_v_q[c0_ra];
      c0_addr_q <= c0_ra;
    end
    if (c1_re) begin
      c1_q      <= comp_mem[c1_ra];
      c1_vq     <= comp_v_q[c1_ra];
      c1_addr_q <= c1_ra;
    end
  end

  // ---------------- cheapest table ----------------
  always_comb begin
    ch_re = 1'b0;
    ch_ra = root0;
    ch_we = 1'b0;
    ch_wa = root0;
    priority case (cmd_i.op)
      OP_CA_RD: ch_re = 1'b1;
      OP_CA_UPD: begin
        ch_re = 1'b1;
        ch_ra = root1;
        ch_we = better;
      end
      OP_CB_UPD: begin
        ch_we = better;
        ch_wa = root1;
      end
      OP_P_RD: begin
        ch_re = 1'b1;
        ch_ra = r_q[NodeW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ch_we) ch_mem[ch_wa] <= '{a: ed_q.a, b: ed_q.b, w: ed_q.w};
    if (ch_re) begin
      ch_q  <= ch_mem[ch_ra];
      chv_q <= ch_v_q[ch_ra];
    end
  end

  // ---------------- control-side registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q    <= NcW'(MaxNodes);
      cnt_q           <= '0;
      e_q             <= '0;
      r_q             <= '0;
      j_q             <= '0;
      joins_q         <= '0;
      drop_q          <= 1'b0;
      any_cross_q     <= 1'b0;
      total_q         <= '0;
      comp_v_q        <= '0;
      ch_v_q          <= '0;
      pend_v_q        <= 1'b0;
      result_strobe_o <= 1'b0;
    end else begin
      result_strobe_o <= ((cmd_i.op == OP_JOIN) && pend_v_q) || (cmd_i.op == OP_FINISH);
      if (cfg_we_i) node_count_q <= cfg_data_i;
      if (comp_we) comp_v_q[c0_addr_q] <= 1'b1;
      if (ch_we) ch_v_q[ch_wa] <= 1'b1;
      unique case (cmd_i.op)
        OP_LOAD: begin
          if (load_fits) cnt_q <= cnt_q + 1'b1;
          else drop_q <= 1'b1;
        end
        OP_ROUND: begin
          e_q         <= '0;
          any_cross_q <= 1'b0;
          ch_v_q      <= '0;
        end
        OP_E_RD:    e_q <= e_q + 1'b1;
        OP_CA_RD:   any_cross_q <= 1'b1;
        OP_AP_INIT: r_q <= '0;
        OP_P_RD:    r_q <= r_q + 1'b1;
        OP_JOIN: begin
          j_q      <= '0;
          joins_q  <= joins_q + 1'b1;
          total_q  <= total_sum;
          pend_v_q <= 1'b1;
        end
        OP_SWEEP: j_q <= j_q + 1'b1;
        OP_FINISH: begin
          cnt_q    <= '0;
          joins_q  <= '0;
          drop_q   <= 1'b0;
          total_q  <= '0;
          comp_v_q <= '0;
          pend_v_q <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // join bounds and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_JOIN) begin
      hi_q       <= (root0 > root1) ? root0 : root1;
      lo_q       <= (root0 > root1) ? root1 : root0;
      pend_q     <= ch_q;
      pend_tot_q <= total_sum;
      if (pend_v_q) begin
        tree_a_o        <= pend_q.a;
        tree_b_o        <= pend_q.b;
        tree_weight_o   <= pend_q.w;
        running_total_o <= pend_tot_q;
        edge_valid_o    <= 1'b1;
        dropped_o       <= drop_q;
        final_item_o    <= 1'b0;
      end
    end else if (cmd_i.op == OP_FINISH) begin
      dropped_o    <= drop_q;
      final_item_o <= 1'b1;
      edge_valid_o <= pend_v_q;
      if (pend_v_q) begin
        tree_a_o        <= pend_q.a;
        tree_b_o        <= pend_q.b;
        tree_weight_o   <= pend_q.w;
        running_total_o <= pend_tot_q;
      end else begin
        tree_a_o        <= '0;
        tree_b_o        <= '0;
        tree_weight_o   <= '0;
        running_total_o <= '0;
      end
    end
  end

  assign status_o.scan_end    = (e_q == cnt_q);
  assign status_o.edge_ok     = ed_q.live && ({1'b0, ed_q.a} < n_eff) &&
                                ({1'b0, ed_q.b} < n_eff);
  assign status_o.same_root   = (root0 == root1);
  assign status_o.any_cross   = any_cross_q;
  assign status_o.r_end       = (r_q == NcW'(MaxNodes));
  assign status_o.pick_valid  = chv_q;
  assign status_o.sweep_done  = j_q[NodeW];
  assign status_o.forest_done = (joins_q == n_eff - 1'b1);

endmodule

@@ hw/rtl/bmst_chk.sv @@
module bmst_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic last_edge_i,
  input logic result_strobe_o,
  input logic edge_valid_o,
  input logic final_item_o
);

  // the final beat closes the run, nothing follows right after it
  a_final_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && final_item_o |=> !result_strobe_o)
    else $error("beat directly after final beat");

  // an empty beat only ever stands alone as the final one
  a_empty_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && !edge_valid_o |-> final_item_o)
    else $error("empty beat not marked final");

  // last edge starts the run
  a_run_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && last_edge_i |=> busy_o)
    else $error("run did not start on last edge");

  // no beats while idle, apart from the final one
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o && $past(!busy_o) |-> !result_strobe_o)
    else $error("beat while idle");

  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && !final_item_o |-> busy_o)
    else $error("non-final beat outside a run");

endmodule

bind boruvka_mst_engine_top bmst_chk u_bmst_chk (.*);
